// ----- rtl/segmented_bump_allocator_defines.svh -----
// assertion macros for the segmented bump allocator
// expects clk and rst_n in the scope of the module that uses them
`ifndef SEGMENTED_BUMP_ALLOCATOR_DEFINES_SVH
`define SEGMENTED_BUMP_ALLOCATOR_DEFINES_SVH

// same-cycle implication, off during reset
`define SBA_ASSERT_HOLD(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sba assertion failed");

// next-cycle implication, off during reset
`define SBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sba assertion failed");

`endif

// ----- rtl/sba_pkg.sv -----
// shared widths, operation codes and register indexes of the segmented bump allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sba_pkg;

  localparam int KIND_W     = 3;
  localparam int REQ_W      = 32;
  localparam int ADDR_W     = 34;
  localparam int POS_W      = 33;
  localparam int FREE_W     = 35;
  localparam int CAP_W      = 32;
  localparam int SEG_CNT_W  = 3;
  localparam int BUDGET_W   = 34;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 34;
  localparam int RND_W      = 33;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 72;

  localparam logic [KIND_W-1:0] KIND_ALLOC   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SAVE    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RESTORE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RESET   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUERY   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_SEG_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_CAP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd4;

  localparam logic [SEG_CNT_W-1:0] SEG_CNT_RESET = 3'd1;
  localparam logic [CAP_W-1:0]     THRESH_RESET  = 32'(64 * 1024);

endpackage

`default_nettype wire

// ----- rtl/sba_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module sba_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/sba_round.sv -----
// rounds a request size down to a multiple of the alignment (caller adds align - 1)
// depends on sba_pkg; mask for power-of-two alignment, radix-16 remainder otherwise
`timescale 1ns / 1ps
`default_nettype none

module sba_round #(
  parameter int ALIGN = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [sba_pkg::RND_W-1:0] x,
  output logic                    done,
  output logic [sba_pkg::RND_W-1:0] y
);

  import sba_pkg::*;

  generate
    if ((ALIGN & (ALIGN - 1)) == 0) begin : g_pow2
      logic             done_r;
      logic [RND_W-1:0] y_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
        if (start) begin
          y_r <= x & ~RND_W'(ALIGN - 1);
        end
      end

      assign done = done_r;
      assign y    = y_r;
    end else begin : g_div
      localparam int STEPS = (RND_W + 3) / 4;
      localparam int PW    = STEPS * 4;
      localparam int RW    = $clog2(ALIGN) + 1;
      localparam int CNTW  = $clog2(STEPS + 1);

      logic [RND_W-1:0] x_r;
      logic [PW-1:0]    sh_r;
      logic [RW-1:0]    rem_r;
      logic [RW-1:0]    rem_nxt;
      logic [CNTW-1:0]  cnt_r;
      logic             busy_r;
      logic             done_r;

      // four dividend bits per cycle, msb first
      always_comb begin
        rem_nxt = rem_r;
        for (int k = 0; k < 4; k++) begin
          rem_nxt = {rem_nxt[RW-2:0], sh_r[PW-1-k]};
          if (rem_nxt >= RW'(ALIGN)) begin
            rem_nxt = rem_nxt - RW'(ALIGN);
          end
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          busy_r <= 1'b0;
          done_r <= 1'b0;
          cnt_r  <= '0;
        end else begin
          done_r <= 1'b0;
          if (start) begin
            busy_r <= 1'b1;
            cnt_r  <= '0;
          end else if (busy_r) begin
            cnt_r <= cnt_r + CNTW'(1);
            if (cnt_r == CNTW'(STEPS - 1)) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
        end
        if (start) begin
          x_r   <= x;
          sh_r  <= PW'(x);
          rem_r <= '0;
        end else if (busy_r) begin
          rem_r <= rem_nxt;
          sh_r  <= sh_r << 4;
        end
      end

      assign done = done_r;
      assign y    = x_r - RND_W'(rem_r);
    end
  endgenerate

endmodule

`default_nettype wire

// ----- rtl/segmented_bump_allocator.sv -----
// sequence: an accepted item goes to the size rounder (allocate only), then one fill ram read
// step and one evaluate step per segment visited, then finish and done; kinds without a walk,
// or an empty segment count, go straight to finish, and the result is registered in done
// throughput: one item at a time; next item accepted once the result is registered
// reset: synchronous active low; per-entry valid bits make all positions read as zero
`timescale 1ns / 1ps
`default_nettype none
`include "segmented_bump_allocator_defines.svh"

module segmented_bump_allocator #(
  parameter int NUM_SEGMENTS = 4,
  parameter int ALIGN_BYTES  = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // request_bytes [31:0], query_address [65:32], zero pad
  input  logic [sba_pkg::IN_DATA_W-1:0]    in_tdata,
  // kind
  input  logic [sba_pkg::KIND_W-1:0]       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // granted, block_address, overflow_error, exhausted, free_bytes, in_pool
  output logic [sba_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_we,
  input  logic [sba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sba_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import sba_pkg::*;

  localparam int IW = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
  localparam int CW = $clog2(NUM_SEGMENTS + 1);
  localparam int NW = (CW > SEG_CNT_W) ? CW : SEG_CNT_W;
  localparam int BW = IW + ADDR_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RND  = 6'b000010,
    S_RD   = 6'b000100,
    S_EV   = 6'b001000,
    S_FIN  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state_r;

  logic [SEG_CNT_W-1:0] seg_cnt_r;
  logic [CAP_W-1:0]     cap_r;
  logic [CAP_W-1:0]     res_r;
  logic [BUDGET_W-1:0]  budget_r;
  logic [CAP_W-1:0]     thr_r;

  logic [KIND_W-1:0]    kind_r;
  logic [ADDR_W-1:0]    q_r;
  logic [REQ_W-1:0]     blk_r;
  logic                 ovf_r;
  logic                 granted_r;
  logic [ADDR_W-1:0]    addr_r;
  logic                 inpool_r;
  logic [CAP_W-1:0]     max_r;
  logic [NW-1:0]        idx_r;
  logic [BW-1:0]        base_r;
  logic [FREE_W-1:0]    free_r;
  logic [FREE_W-1:0]    sfree_r;
  logic                 exh_r;
  logic [NUM_SEGMENTS-1:0] fill_vld_r;
  logic [NUM_SEGMENTS-1:0] save_vld_r;
  logic                 out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic              accept;
  logic              walk_kind;
  logic [NW-1:0]     n_seg;
  logic [NW-1:0]     idx_nx;
  logic              last_seg;
  logic [CAP_W-1:0]  cap_less_res;
  logic [CAP_W-1:0]  end_v;
  logic [POS_W-1:0]  fill_rdata;
  logic [POS_W-1:0]  save_rdata;
  logic [POS_W-1:0]  fill_v;
  logic [POS_W-1:0]  save_v;
  logic [POS_W-1:0]  room_diff;
  logic [CAP_W-1:0]  room_v;
  logic              fits;
  logic [BW-1:0]     addr_sum;
  logic [BW-1:0]     q_ext;
  logic              q_hit;
  logic              stop_walk;
  logic              fill_we;
  logic [POS_W-1:0]  fill_wdata;
  logic              save_we;
  logic              rnd_start;
  logic              rnd_done;
  logic [RND_W-1:0]  rnd_x;
  logic [RND_W-1:0]  rnd_y;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign walk_kind = (in_tuser == KIND_SAVE) || (in_tuser == KIND_RESTORE) ||
                     (in_tuser == KIND_QUERY);

  assign n_seg  = (NW'(seg_cnt_r) > NW'(NUM_SEGMENTS)) ? NW'(NUM_SEGMENTS) : NW'(seg_cnt_r);
  assign idx_nx = idx_r + NW'(1);
  assign last_seg = (idx_nx == n_seg);

  assign cap_less_res = (cap_r >= res_r) ? (cap_r - res_r) : '0;
  assign end_v        = last_seg ? cap_less_res : cap_r;

  assign fill_v = fill_vld_r[idx_r[IW-1:0]] ? fill_rdata : '0;
  assign save_v = save_vld_r[idx_r[IW-1:0]] ? save_rdata : '0;

  assign room_diff = {1'b0, end_v} - fill_v;
  assign room_v    = ({1'b0, end_v} > fill_v) ? room_diff[CAP_W-1:0] : '0;
  assign fits      = (FREE_W'(blk_r) <= free_r) && (blk_r <= room_v);
  assign addr_sum  = base_r + BW'(fill_v);
  assign q_ext     = BW'(q_r);
  assign q_hit     = (q_ext >= base_r) && (q_ext < base_r + BW'(end_v));

  assign stop_walk = last_seg || ((kind_r == KIND_ALLOC) && fits) ||
                     ((kind_r == KIND_QUERY) && q_hit);

  assign fill_we    = (state_r == S_EV) &&
                      (((kind_r == KIND_ALLOC) && fits) || (kind_r == KIND_RESTORE));
  assign fill_wdata = (kind_r == KIND_RESTORE) ? save_v : (fill_v + POS_W'(blk_r));
  assign save_we    = (state_r == S_EV) && (kind_r == KIND_SAVE);

  assign rnd_start = accept && (in_tuser == KIND_ALLOC);
  assign rnd_x     = RND_W'(in_tdata[REQ_W-1:0]) + RND_W'(ALIGN_BYTES - 1);

  sba_round #(
    .ALIGN (ALIGN_BYTES)
  ) u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rnd_start),
    .x     (rnd_x),
    .done  (rnd_done),
    .y     (rnd_y)
  );

  sba_ram #(
    .WIDTH (POS_W),
    .DEPTH (NUM_SEGMENTS)
  ) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (idx_r[IW-1:0]),
    .wdata (fill_wdata),
    .raddr (idx_r[IW-1:0]),
    .rdata (fill_rdata)
  );

  sba_ram #(
    .WIDTH (POS_W),
    .DEPTH (NUM_SEGMENTS)
  ) u_save_ram (
    .clk   (clk),
    .we    (save_we),
    .waddr (idx_r[IW-1:0]),
    .wdata (fill_v),
    .raddr (idx_r[IW-1:0]),
    .rdata (save_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_cnt_r <= SEG_CNT_RESET;
      cap_r     <= '0;
      res_r     <= '0;
      budget_r  <= '0;
      thr_r     <= THRESH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEG_COUNT: seg_cnt_r <= cfg_wdata[SEG_CNT_W-1:0];
        CFG_SEG_CAP:   cap_r     <= cfg_wdata[CAP_W-1:0];
        CFG_RESERVE:   res_r     <= cfg_wdata[CAP_W-1:0];
        CFG_BUDGET:    budget_r  <= cfg_wdata[BUDGET_W-1:0];
        CFG_THRESHOLD: thr_r     <= cfg_wdata[CAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_r      <= '0;
      sfree_r     <= '0;
      exh_r       <= 1'b0;
      fill_vld_r  <= '0;
      save_vld_r  <= '0;
      out_valid_r <= 1'b0;
      granted_r   <= 1'b0;
      ovf_r       <= 1'b0;
      inpool_r    <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            kind_r    <= in_tuser;
            q_r       <= in_tdata[REQ_W+ADDR_W-1:REQ_W];
            granted_r <= 1'b0;
            ovf_r     <= 1'b0;
            inpool_r  <= 1'b0;
            addr_r    <= '0;
            max_r     <= '0;
            idx_r     <= '0;
            base_r    <= '0;
            if (in_tuser == KIND_ALLOC) begin
              state_r <= S_RND;
            end else if (walk_kind && (n_seg != '0)) begin
              state_r <= S_RD;
            end else begin
              state_r <= S_FIN;
            end
          end
        end
        S_RND: begin
          if (rnd_done) begin
            blk_r <= rnd_y[REQ_W-1:0];
            if (rnd_y[RND_W-1]) begin
              ovf_r   <= 1'b1;
              state_r <= S_FIN;
            end else if (n_seg != '0) begin
              state_r <= S_RD;
            end else begin
              state_r <= S_FIN;
            end
          end
        end
        S_RD: begin
          state_r <= S_EV;
        end
        S_EV: begin
          if (fill_we) begin
            fill_vld_r[idx_r[IW-1:0]] <= 1'b1;
          end
          if (save_we) begin
            save_vld_r[idx_r[IW-1:0]] <= 1'b1;
          end
          if ((kind_r == KIND_ALLOC) && fits) begin
            granted_r <= 1'b1;
            addr_r    <= addr_sum[ADDR_W-1:0];
            free_r    <= free_r - FREE_W'(blk_r);
          end else if ((kind_r == KIND_ALLOC) && (room_v > max_r)) begin
            max_r <= room_v;
          end
          if ((kind_r == KIND_QUERY) && q_hit) begin
            inpool_r <= 1'b1;
          end
          if (stop_walk) begin
            state_r <= S_FIN;
          end else begin
            idx_r   <= idx_nx;
            base_r  <= base_r + BW'(cap_r);
            state_r <= S_RD;
          end
        end
        S_FIN: begin
          unique case (kind_r)
            KIND_ALLOC: begin
              if (!ovf_r && !granted_r && (max_r < thr_r)) begin
                exh_r <= 1'b1;
              end
            end
            KIND_SAVE: begin
              sfree_r <= free_r;
            end
            KIND_RESTORE: begin
              free_r <= sfree_r;
              exh_r  <= 1'b0;
            end
            KIND_RESET: begin
              fill_vld_r <= '0;
              free_r     <= FREE_W'(budget_r);
              exh_r      <= 1'b0;
            end
            default: begin
            end
          endcase
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {inpool_r, free_r[ADDR_W-1:0], exh_r, ovf_r, addr_r, granted_r};
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `SBA_ASSERT_NEXT(a_accept_leaves_idle, in_tvalid && in_tready, state_r != S_IDLE)
  `SBA_ASSERT_NEXT(a_done_waits, (state_r == S_DONE) && out_valid_r && !out_tready, state_r == S_DONE)
  `SBA_ASSERT_NEXT(a_fin_to_done, state_r == S_FIN, state_r == S_DONE)
  `SBA_ASSERT_HOLD(a_grant_no_ovf, granted_r, !ovf_r)

endmodule

`default_nettype wire

// ----- tb/tb_segmented_bump_allocator.sv -----
// self-checking testbench for segmented_bump_allocator: a scoreboard class predicts each
// result beat from the accepted requests and the register writes; tasks drive both streams
// depends on sba_pkg and the segmented_bump_allocator rtl
`timescale 1ns / 1ps

module tb_segmented_bump_allocator;
  import sba_pkg::*;

  localparam int NSEG = 4;
  localparam int ALIGN = 8;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE = 32;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 60;
  localparam logic [KIND_W-1:0] KIND_TOP = '1;
  localparam logic [BUDGET_W-1:0] BUDGET_MAX = 34'h3_FFFF_FFFC;

  typedef struct packed {
    bit granted;
    bit [ADDR_W-1:0] block_addr;
    bit ovf;
    bit exh;
    bit [BUDGET_W-1:0] free_bytes;
    bit in_pool;
  } reply_t;

  class arena_scoreboard;
    bit [SEG_CNT_W-1:0] seg_count;
    bit [CAP_W-1:0] seg_cap;
    bit [CAP_W-1:0] reserve;
    bit [BUDGET_W-1:0] budget;
    bit [CAP_W-1:0] threshold;
    bit [POS_W-1:0] fill[NSEG];
    bit [POS_W-1:0] saved_fill[NSEG];
    bit [FREE_W-1:0] free_cnt;
    bit [FREE_W-1:0] saved_free;
    bit exhausted;
    reply_t replies[$];
    int mismatches;

    function new();
      seg_count = SEG_CNT_RESET;
      threshold = THRESH_RESET;
    endfunction

    function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_SEG_COUNT: seg_count = value[SEG_CNT_W-1:0];
        CFG_SEG_CAP:   seg_cap = value[CAP_W-1:0];
        CFG_RESERVE:   reserve = value[CAP_W-1:0];
        CFG_BUDGET:    budget = value[BUDGET_W-1:0];
        CFG_THRESHOLD: threshold = value[CAP_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned in_use();
      return (seg_count > NSEG) ? NSEG : seg_count;
    endfunction

    function longint unsigned seg_limit(int unsigned i, int unsigned n);
      if (i + 1 == n) begin
        return (seg_cap >= reserve) ? seg_cap - reserve : 0;
      end
      return seg_cap;
    endfunction

    function longint unsigned room(int unsigned i, int unsigned n);
      longint unsigned lim;
      lim = seg_limit(i, n);
      return (lim > fill[i]) ? lim - fill[i] : 0;
    endfunction

    function void mark_refusal(int unsigned n);
      longint unsigned largest;
      int unsigned i;
      largest = 0;
      for (i = 0; i < n; i++) begin
        if (room(i, n) > largest) largest = room(i, n);
      end
      if (largest < threshold) exhausted = 1'b1;
    endfunction

    function void note_request(bit [KIND_W-1:0] kind, bit [REQ_W-1:0] req,
                               bit [ADDR_W-1:0] qaddr);
      reply_t r;
      int unsigned n;
      int unsigned i;
      longint unsigned blk;
      longint unsigned base;
      r = '0;
      n = in_use();
      case (kind)
        KIND_ALLOC: begin
          blk = 64'(req) + ALIGN - 1;
          blk = blk - blk % ALIGN;
          if (blk > 64'hFFFF_FFFF) begin
            r.ovf = 1'b1;
          end else if (blk > free_cnt) begin
            mark_refusal(n);
          end else begin
            for (i = 0; i < n; i++) begin
              if (room(i, n) >= blk) begin
                r.block_addr = ADDR_W'(64'(i) * seg_cap + fill[i]);
                fill[i] = POS_W'(fill[i] + blk);
                free_cnt = FREE_W'(free_cnt - blk);
                r.granted = 1'b1;
                break;
              end
            end
            if (!r.granted) mark_refusal(n);
          end
        end
        KIND_SAVE: begin
          for (i = 0; i < n; i++) saved_fill[i] = fill[i];
          saved_free = free_cnt;
        end
        KIND_RESTORE: begin
          for (i = 0; i < n; i++) fill[i] = saved_fill[i];
          free_cnt = saved_free;
          exhausted = 1'b0;
        end
        KIND_RESET: begin
          for (i = 0; i < NSEG; i++) fill[i] = '0;
          free_cnt = budget;
          exhausted = 1'b0;
        end
        KIND_QUERY: begin
          for (i = 0; i < n; i++) begin
            base = 64'(i) * seg_cap;
            if (qaddr >= base && qaddr < base + seg_limit(i, n)) begin
              r.in_pool = 1'b1;
              break;
            end
          end
        end
        default: ;
      endcase
      r.exh = exhausted;
      r.free_bytes = free_cnt[BUDGET_W-1:0];
      replies.push_back(r);
    endfunction

    function void check_reply(bit [OUT_DATA_W-1:0] d);
      reply_t got;
      reply_t want;
      string bad;
      got.granted = d[0];
      got.block_addr = d[34:1];
      got.ovf = d[35];
      got.exh = d[36];
      got.free_bytes = d[70:37];
      got.in_pool = d[71];
      if (replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result beat with nothing pending: %h", d);
        return;
      end
      want = replies.pop_front();
      bad = "";
      if (got.granted != want.granted) bad = {bad, " granted"};
      if (got.block_addr != want.block_addr) bad = {bad, " block_address"};
      if (got.ovf != want.ovf) bad = {bad, " overflow_error"};
      if (got.exh != want.exh) bad = {bad, " exhausted"};
      if (got.free_bytes != want.free_bytes) bad = {bad, " free_bytes"};
      if (got.in_pool != want.in_pool) bad = {bad, " in_pool"};
      if (bad != "") begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch in%s at %0t", bad, $realtime);
          $display("  expected gr=%0d addr=%h ovf=%0d exh=%0d free=%h pool=%0d",
                   want.granted, want.block_addr, want.ovf, want.exh, want.free_bytes,
                   want.in_pool);
          $display("  actual   gr=%0d addr=%h ovf=%0d exh=%0d free=%h pool=%0d",
                   got.granted, got.block_addr, got.ovf, got.exh, got.free_bytes,
                   got.in_pool);
        end
      end
    endfunction

    function int pending();
      return replies.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [KIND_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  arena_scoreboard sb = new();
  int idle_cycles = 0;
  int burst_left = 0;
  bit no_gaps = 1'b0;
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_stall = 0;

  segmented_bump_allocator #(
    .NUM_SEGMENTS(NSEG),
    .ALIGN_BYTES (ALIGN)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_request(in_tuser, in_tdata[31:0], in_tdata[65:32]);
      if (out_tvalid && out_tready) sb.check_reply(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(50, 300);
    end
    rx_mode_left--;
    if (rx_stall > 0) begin
      rx_stall--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: begin
          if ($urandom_range(0, 15) == 0) begin
            rx_stall = $urandom_range(1, 20);
            out_tready <= 1'b0;
          end else begin
            out_tready <= 1'b1;
          end
        end
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic send_item(bit [KIND_W-1:0] kind, bit [REQ_W-1:0] req,
                           bit [ADDR_W-1:0] qaddr);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= IN_DATA_W'({qaddr, req});
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = no_gaps ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic load_config(bit [SEG_CNT_W-1:0] cnt, bit [CAP_W-1:0] cap,
                             bit [CAP_W-1:0] res, bit [BUDGET_W-1:0] bud,
                             bit [CAP_W-1:0] thr);
    write_reg(CFG_SEG_COUNT, CFG_DATA_W'(cnt));
    write_reg(CFG_SEG_CAP, CFG_DATA_W'(cap));
    write_reg(CFG_RESERVE, CFG_DATA_W'(res));
    write_reg(CFG_BUDGET, CFG_DATA_W'(bud));
    write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_config(int ph);
    bit [SEG_CNT_W-1:0] cnt;
    bit [CAP_W-1:0] cap;
    bit [CAP_W-1:0] res;
    bit [CAP_W-1:0] thr;
    bit [63:0] bud;
    bit [63:0] span;
    int r;
    cnt = ($urandom_range(0, 9) < 7) ? SEG_CNT_W'($urandom_range(1, 4)) :
                                       SEG_CNT_W'($urandom_range(0, 7));
    r = $urandom_range(0, 99);
    if (r < 40) cap = $urandom_range(0, 64) * 8 + (($urandom_range(0, 3) == 0) ?
                      $urandom_range(1, 7) : 0);
    else if (r < 70) cap = $urandom_range(1, 4096);
    else if (r < 90) cap = $urandom();
    else cap = $urandom_range(0, 1) ? '1 : '0;
    r = $urandom_range(0, 99);
    if (r < 40) res = 0;
    else if (r < 70) res = $urandom_range(0, cap >> 2);
    else if (r < 90) res = $urandom_range(0, cap);
    else res = cap + $urandom_range(1, 100);
    span = 64'(cnt) * cap;
    r = $urandom_range(0, 99);
    if (r < 30) bud = span;
    else if (r < 60) bud = span * $urandom_range(0, 1000) / 1000;
    else if (r < 80) bud = {$urandom_range(0, 3), $urandom()};
    else bud = $urandom_range(0, 256);
    r = $urandom_range(0, 99);
    if (r < 30) thr = THRESH_RESET;
    else if (r < 60) thr = $urandom_range(0, cap);
    else if (r < 80) thr = 0;
    else thr = $urandom();
    case (ph)
      0: cnt = 0;
      1: cnt = '1;
      2: begin
        cap = '1;
        res = 0;
        bud = BUDGET_MAX;
        thr = '1;
      end
      3: begin
        cap = 0;
        thr = 0;
      end
      4: res = '1;
      5: cnt = SEG_CNT_W'(NSEG + 1);
      default: ;
    endcase
    if (bud > BUDGET_MAX) bud = BUDGET_MAX;
    load_config(cnt, cap, res, bud[BUDGET_W-1:0], thr);
  endtask

  function automatic bit [KIND_W-1:0] pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return KIND_ALLOC;
    if (r < 68) return KIND_QUERY;
    if (r < 76) return KIND_SAVE;
    if (r < 84) return KIND_RESTORE;
    if (r < 90) return KIND_RESET;
    return KIND_W'($urandom_range(KIND_QUERY + 1, KIND_TOP));
  endfunction

  function automatic bit [REQ_W-1:0] pick_request();
    int r;
    bit [CAP_W-1:0] span;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom();
    if (r < 16) begin
      case ($urandom_range(0, 4))
        0: return 0;
        1: return '1;
        2: return 32'hFFFF_FFF8;
        3: return 32'hFFFF_FFF9;
        default: return 1;
      endcase
    end
    span = (sb.seg_cap == 0) ? 64 : sb.seg_cap;
    if (r < 30) return $urandom_range(0, span);
    if (r < 60) return $urandom_range(0, span >> 1);
    return $urandom_range(0, span >> 3);
  endfunction

  function automatic bit [ADDR_W-1:0] pick_query();
    bit [63:0] base;
    bit [63:0] a;
    if ($urandom_range(0, 9) < 4) return {2'($urandom_range(0, 3)), 32'($urandom())};
    base = 64'($urandom_range(0, NSEG)) * sb.seg_cap;
    case ($urandom_range(0, 3))
      0: a = base + $urandom_range(0, sb.seg_cap);
      1: a = base + sb.seg_cap - sb.reserve + $urandom_range(0, 2) - 1;
      2: a = base + $urandom_range(0, 2) - 1;
      default: a = base + sb.seg_cap + $urandom_range(0, 2) - 1;
    endcase
    return a[ADDR_W-1:0];
  endfunction

  initial begin
    bit [KIND_W-1:0] kind;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset configuration: one segment of zero bytes, empty budget
    pace(); send_item(KIND_ALLOC, 0, 0);
    pace(); send_item(KIND_ALLOC, '1, 0);
    pace(); send_item(KIND_ALLOC, 32'hFFFF_FFF8, 0);
    pace(); send_item(KIND_W'(KIND_QUERY + 1), '1, '1);
    pace(); send_item(KIND_W'(KIND_TOP - 1), 0, 0);
    pace(); send_item(KIND_TOP, 0, 0);
    pace(); send_item(KIND_QUERY, 0, 0);
    drain();
    load_config(SEG_CNT_W'(NSEG), 64, 8, 200, 32);
    pace(); send_item(KIND_RESET, 0, 0);
    pace(); send_item(KIND_ALLOC, 60, 0);
    pace(); send_item(KIND_ALLOC, 1, 0);
    pace(); send_item(KIND_SAVE, 0, 0);
    pace(); send_item(KIND_ALLOC, 56, 0);
    pace(); send_item(KIND_ALLOC, 48, 0);
    pace(); send_item(KIND_ALLOC, 40, 0);
    pace(); send_item(KIND_QUERY, 0, 63);
    pace(); send_item(KIND_QUERY, 0, 64);
    pace(); send_item(KIND_QUERY, 0, 247);
    pace(); send_item(KIND_QUERY, 0, 248);
    pace(); send_item(KIND_QUERY, 0, '1);
    pace(); send_item(KIND_RESTORE, 0, 0);
    pace(); send_item(KIND_ALLOC, 32'hFFFF_FFF9, 0);
    pace(); send_item(KIND_ALLOC, 200, 0);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      random_config(ph);
      no_gaps = (ph % 4 == 1);
      if ($urandom_range(0, 3) != 0) begin
        pace();
        send_item(KIND_RESET, $urandom(), pick_query());
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 49) == 0) drain();
        pace();
        kind = pick_kind();
        send_item(kind, (kind == KIND_ALLOC) ? pick_request() : $urandom(), pick_query());
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- segmented_bump_allocator.f -----
+incdir+rtl
rtl/sba_pkg.sv
rtl/sba_ram.sv
rtl/sba_round.sv
rtl/segmented_bump_allocator.sv
tb/tb_segmented_bump_allocator.sv
